>>> hdl/kbt_pkg.sv
// Package for the keyed record table: sizes, request and status codes,
// the record entry type and the control bundle that drives the cell row.
// No dependencies.
package kbt_pkg;

    localparam int CAPACITY    = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LIST_W = (CNT_W > 5) ? CNT_W : 5;

    localparam int REQ_W  = 3;
    localparam int KEY_W  = 32;
    localparam int NAME_W = 32;
    localparam int POP_W  = 31;
    localparam int SLOT_W = 4;
    localparam int ECNT_W = 5;

    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_INSERT = 3'd0;
    localparam t_req REQ_UPDATE = 3'd1;
    localparam t_req REQ_DELETE = 3'd2;
    localparam t_req REQ_LOOKUP = 3'd3;
    localparam t_req REQ_LIST   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [NAME_W-1:0]       name_ref;
        logic [POP_W-1:0]        population;
    } t_entry;

    typedef struct packed {
        logic             shift;
        logic             compact;
        logic [IDX_W-1:0] del_slot;
    } t_cell_ctl;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        t_entry            entry;
    } t_result;

    typedef struct packed {
        t_result           res;
        logic [ECNT_W-1:0] entry_count;
        logic              last;
    } t_out;

endpackage

>>> hdl/kbt_req_if.sv
// Request channel of the keyed record table: valid/ready plus request payload.
// Depends on kbt_pkg.
interface kbt_req_if import kbt_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key;
    logic [NAME_W-1:0]       name_ref;
    logic [POP_W-1:0]        population;

    modport source (output valid, req_type, key, name_ref, population, input ready);
    modport sink   (input valid, req_type, key, name_ref, population, output ready);

endinterface

>>> hdl/kbt_rsp_if.sv
// Result channel of the keyed record table: valid/ready plus result payload.
// Depends on kbt_pkg.
interface kbt_rsp_if import kbt_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [SLOT_W-1:0]       slot;
    logic signed [KEY_W-1:0] key_out;
    logic [NAME_W-1:0]       name_ref_out;
    logic [POP_W-1:0]        population_out;
    logic [ECNT_W-1:0]       entry_count;
    logic                    last;

    modport source (output valid, status, slot, key_out, name_ref_out, population_out,
                    entry_count, last, input ready);
    modport sink   (input valid, status, slot, key_out, name_ref_out, population_out,
                    entry_count, last, output ready);

endinterface

>>> hdl/kbt_cell.sv
// One storage cell of the record row: holds one entry and loads it from its
// right-hand neighbor on a rotate step or a compaction step. Depends on kbt_pkg.
module kbt_cell import kbt_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_pos,
    input  t_entry           i_next,
    output t_entry           o_entry
);

    t_entry r_entry;
    logic   load_en;

    // compaction pulls every entry at or above the removed slot down by one
    always_comb begin
        load_en = i_ctl.shift | (i_ctl.compact & (i_pos >= i_ctl.del_slot));
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hdl/kbt_ctrl.sv
// Sequencer of the record table: request decode, rotation step counter, key
// compare at the row head, result register and output beat register.
// Depends on kbt_pkg, kbt_req_if and kbt_rsp_if.
module kbt_ctrl import kbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kbt_req_if.sink    i_req,
    kbt_rsp_if.source  o_rsp,
    input  t_entry     i_head,
    output t_entry     o_tail,
    output t_cell_ctl  o_cell_ctl
);

    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_step;
    logic [CNT_W-1:0]  r_count;
    logic              r_found;
    logic [IDX_W-1:0]  r_del_slot;
    t_req              r_req;
    logic signed [KEY_W-1:0] r_key;
    logic [NAME_W-1:0] r_name;
    logic [POP_W-1:0]  r_pop;
    t_result           r_res;
    logic              r_out_valid;
    t_out              r_out;

    logic [LIST_W-1:0] step_l;
    logic [LIST_W-1:0] count_l;
    logic              in_range;
    logic              is_search;
    logic              is_match;
    logic              ins_here;
    logic              list_emit;
    logic              list_last;
    logic              last_step;
    logic              out_free;
    logic              stall;
    logic              accept;
    logic              advance;
    t_entry            new_entry;
    t_entry            upd_entry;
    t_status           err_status;

    always_comb begin
        step_l    = LIST_W'(r_step);
        count_l   = LIST_W'(r_count);
        in_range  = step_l < count_l;
        is_search = (r_req == REQ_UPDATE) || (r_req == REQ_DELETE) || (r_req == REQ_LOOKUP);
        is_match  = is_search && in_range && !r_found && (i_head.key == r_key);
        ins_here  = (r_req == REQ_INSERT) && (CNT_W'(r_step) == r_count);
        list_emit = (r_req == REQ_LIST) && in_range && (step_l < LIST_W'(MAX_RESULTS));
        list_last = ((step_l + LIST_W'(1)) == count_l)
                 || (step_l == LIST_W'(MAX_RESULTS - 1));
        last_step = r_step == IDX_W'(CAPACITY - 1);
        out_free  = !r_out_valid || o_rsp.ready;
        stall     = list_emit && !out_free;
        accept    = i_req.valid && i_req.ready;
        advance   = (r_state == S_SCAN) && !stall;
        new_entry = '{key: r_key, name_ref: r_name, population: r_pop};
        upd_entry = '{key: i_head.key, name_ref: r_name, population: r_pop};
    end

    always_comb begin
        case (i_req.req_type) inside
            REQ_INSERT: err_status = ST_FULL;
            REQ_LIST:   err_status = ST_EMPTY;
            default:    err_status = ST_NOTFOUND;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type) inside
                        REQ_INSERT: begin
                            n_state = (r_count == CNT_W'(CAPACITY)) ? S_DONE : S_SCAN;
                        end
                        REQ_UPDATE, REQ_DELETE, REQ_LOOKUP: begin
                            n_state = S_SCAN;
                        end
                        REQ_LIST: begin
                            n_state = (r_count == '0) ? S_DONE : S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!stall && last_step) begin
                    if (r_req == REQ_LIST) begin
                        n_state = S_IDLE;
                    end else if ((r_req == REQ_DELETE) && (r_found || is_match)) begin
                        n_state = S_COMPACT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_COMPACT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready         = 1'b0;
        o_cell_ctl.shift    = 1'b0;
        o_cell_ctl.compact  = 1'b0;
        o_cell_ctl.del_slot = r_del_slot;
        o_tail              = i_head;
        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_SCAN: begin
                o_cell_ctl.shift = !stall;
                if (ins_here) begin
                    o_tail = new_entry;
                end else if (is_match && (r_req == REQ_UPDATE)) begin
                    o_tail = upd_entry;
                end
            end
            S_COMPACT: begin
                o_cell_ctl.compact = 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((advance && list_emit) || ((r_state == S_DONE) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_step  <= '0;
                r_found <= 1'b0;
            end
            if (advance) begin
                r_step <= IDX_W'(r_step + IDX_W'(1));
                if (is_match || ins_here) begin
                    r_found <= 1'b1;
                end
                if (last_step && (r_req == REQ_INSERT)) begin
                    r_count <= CNT_W'(r_count + CNT_W'(1));
                end
            end
            if (r_state == S_COMPACT) begin
                r_count <= CNT_W'(r_count - CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req     <= i_req.req_type;
            r_key     <= i_req.key;
            r_name    <= i_req.name_ref;
            r_pop     <= i_req.population;
            r_res     <= '{status: err_status, slot: '0, entry: '0};
        end
        if (advance) begin
            if (is_match) begin
                r_del_slot <= r_step;
                r_res      <= '{status: ST_OK, slot: SLOT_W'(r_step),
                                entry: (r_req == REQ_UPDATE) ? upd_entry : i_head};
            end
            if (ins_here) begin
                r_res <= '{status: ST_OK, slot: SLOT_W'(r_step), entry: new_entry};
            end
            if (list_emit) begin
                r_out <= '{res: '{status: ST_OK, slot: SLOT_W'(r_step), entry: i_head},
                           entry_count: ECNT_W'(r_count), last: list_last};
            end
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out <= '{res: r_res, entry_count: ECNT_W'(r_count), last: 1'b1};
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.res.status;
    assign o_rsp.slot           = r_out.res.slot;
    assign o_rsp.key_out        = r_out.res.entry.key;
    assign o_rsp.name_ref_out   = r_out.res.entry.name_ref;
    assign o_rsp.population_out = r_out.res.entry.population;
    assign o_rsp.entry_count    = r_out.entry_count;
    assign o_rsp.last           = r_out.last;

endmodule

>>> hdl/keyed_record_table.sv
// Keyed record table: a compacted table of CAPACITY records held in a row of
// cells that rotates past one key comparator at the head.
// Depends on kbt_pkg, kbt_req_if, kbt_rsp_if, kbt_cell and kbt_ctrl.
//
// Usage:
//   i_req carries one request beat (insert, update, delete, lookup, list);
//   o_rsp carries result beats, the final one of each request with last set.
//   A request is taken only while the table is idle. Every accepted request
//   but a full-table insert, an empty-table list or an unknown code rotates
//   the whole row once, and a search compares the entry at the head against
//   the key; the result beat follows the rotation (a successful delete first
//   compacts the row). A full table on insert or an empty table on list
//   answers without a rotation. Unknown request codes are taken and dropped.
//   A list sends up to 16 beats, one per rotation step that holds an entry.
//   A new request is not taken before the previous rotation has ended: the
//   single head comparator sees one entry per cycle while the row rotates.
//   When the receiver stalls, the result beat is held in the output register;
//   during a list the row stops rotating until the pending beat is taken.
//   Reset empties the table (entry count zero) at the next clock edge.
module keyed_record_table import kbt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kbt_req_if.sink   i_req,
    kbt_rsp_if.source o_rsp
);

    t_entry    cell_q [CAPACITY];
    t_entry    tail;
    t_cell_ctl cell_ctl;

    kbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_head     (cell_q[0]),
        .o_tail     (tail),
        .o_cell_ctl (cell_ctl)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry next_entry;
        if (g == CAPACITY - 1) begin : g_tail
            assign next_entry = tail;
        end else begin : g_body
            assign next_entry = cell_q[g + 1];
        end
        kbt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_pos   (IDX_W'(g)),
            .i_next  (next_entry),
            .o_entry (cell_q[g])
        );
    end

endmodule

>>> tb/sv/record_table_checker.sv
// Checker for the keyed record table: watches the request and result channels,
// keeps its own copy of the table and compares every result beat in order.
// Depends on kbt_pkg, kbt_req_if and kbt_rsp_if.
module record_table_checker import kbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    kbt_req_if   i_req,
    kbt_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_beats_checked
);

    t_entry records [CAPACITY];
    int     record_count;
    t_out   expected_beats [$];

    function automatic int find_first(logic signed [KEY_W-1:0] key);
        for (int i = 0; i < record_count; i++) begin
            if (records[i].key == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void push_beat(t_status status, int slot, t_entry entry, logic last);
        t_out beat;
        beat.res.status = status;
        beat.res.slot = SLOT_W'(slot);
        beat.res.entry = entry;
        beat.entry_count = ECNT_W'(record_count);
        beat.last = last;
        expected_beats.push_back(beat);
    endfunction

    function automatic void apply_request(t_req req, logic signed [KEY_W-1:0] key,
                                          logic [NAME_W-1:0] name, logic [POP_W-1:0] pop);
        int     hit;
        int     n;
        t_entry removed;
        hit = find_first(key);
        case (req)
            REQ_INSERT: begin
                if (record_count >= CAPACITY) begin
                    push_beat(ST_FULL, 0, t_entry'(0), 1'b1);
                end else begin
                    records[record_count] = '{key: key, name_ref: name, population: pop};
                    record_count++;
                    push_beat(ST_OK, record_count - 1, records[record_count - 1], 1'b1);
                end
            end
            REQ_UPDATE, REQ_LOOKUP: begin
                if (hit < 0) begin
                    push_beat(ST_NOTFOUND, 0, t_entry'(0), 1'b1);
                end else begin
                    if (req == REQ_UPDATE) begin
                        records[hit].name_ref = name;
                        records[hit].population = pop;
                    end
                    push_beat(ST_OK, hit, records[hit], 1'b1);
                end
            end
            REQ_DELETE: begin
                if (hit < 0) begin
                    push_beat(ST_NOTFOUND, 0, t_entry'(0), 1'b1);
                end else begin
                    removed = records[hit];
                    for (int i = hit; i + 1 < record_count; i++) begin
                        records[i] = records[i + 1];
                    end
                    record_count--;
                    push_beat(ST_OK, hit, removed, 1'b1);
                end
            end
            REQ_LIST: begin
                if (record_count == 0) begin
                    push_beat(ST_EMPTY, 0, t_entry'(0), 1'b1);
                end else begin
                    n = (record_count > MAX_RESULTS) ? MAX_RESULTS : record_count;
                    for (int i = 0; i < n; i++) begin
                        push_beat(ST_OK, i, records[i], i == n - 1);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void compare_field(string field, logic [63:0] expected,
                                          logic [63:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0h, actual %0h", field, expected, actual);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            record_count = 0;
            expected_beats.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                o_beats_checked++;
                if (expected_beats.size() == 0) begin
                    $error("result beat with no request pending: status %0d slot %0d",
                           i_rsp.status, i_rsp.slot);
                    o_fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("status", want.res.status, i_rsp.status);
                    compare_field("slot", want.res.slot, i_rsp.slot);
                    compare_field("key_out", want.res.entry.key, i_rsp.key_out);
                    compare_field("name_ref_out", want.res.entry.name_ref, i_rsp.name_ref_out);
                    compare_field("population_out", want.res.entry.population,
                                  i_rsp.population_out);
                    compare_field("entry_count", want.entry_count, i_rsp.entry_count);
                    compare_field("last", want.last, i_rsp.last);
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.req_type, i_req.key, i_req.name_ref, i_req.population);
            end
        end
        o_outstanding = expected_beats.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the keyed record table testbench: clock, reset, request and result
// traffic with random idling, a watchdog and the verdict.
// Depends on kbt_pkg, kbt_req_if, kbt_rsp_if, keyed_record_table, record_table_checker.
module tb_top;
    import kbt_pkg::*;

    localparam int PHASE_ITEMS    = 17;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 3 * (CAPACITY + 3);
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   beats_checked;
    int   requests_sent;
    int   src_gap_max;
    int   snk_gap_max;
    bit   hold_results;

    logic signed [KEY_W-1:0] key_pool [8];

    kbt_req_if req_ch ();
    kbt_rsp_if rsp_ch ();

    keyed_record_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    record_table_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req           (req_ch),
        .i_rsp           (rsp_ch),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_beats_checked (beats_checked)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_request(t_req req, logic signed [KEY_W-1:0] key,
                                logic [NAME_W-1:0] name, logic [POP_W-1:0] pop);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = req;
        req_ch.key = key;
        req_ch.name_ref = name;
        req_ch.population = pop;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        if ($urandom_range(3, 0) != 0) begin
            return key_pool[3'($urandom_range(7, 0))];
        end
        return $urandom;
    endfunction

    function automatic t_req pick_request(int ins_w, int del_w);
        int r;
        r = $urandom_range(99, 0);
        if (r < ins_w) return REQ_INSERT;
        if (r < ins_w + del_w) return REQ_DELETE;
        if (r < ins_w + del_w + 12) return REQ_UPDATE;
        if (r < ins_w + del_w + 24) return REQ_LOOKUP;
        if (r < ins_w + del_w + 32) return REQ_LIST;
        return t_req'($urandom_range(7, REQ_LIST + 1));
    endfunction

    task automatic run_phase(int src_max, int snk_max, int ins_w, int del_w, bit long_stall);
        int   counted;
        t_req req;
        src_gap_max = src_max;
        snk_gap_max = snk_max;
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            if (long_stall && counted == 8) begin
                hold_results = 1'b1;
            end
            req = pick_request(ins_w, del_w);
            send_request(req, pick_key(), $urandom, POP_W'($urandom));
            if (req <= REQ_LIST) begin
                counted++;
            end
        end
        wait_drained();
    endtask

    initial begin : result_sink
        int gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_results) begin
                rsp_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_results = 1'b0;
            end
            gap = $urandom_range(snk_gap_max, 0);
            if (gap > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key = '0;
        req_ch.name_ref = '0;
        req_ch.population = '0;
        src_gap_max = 3;
        snk_gap_max = 3;
        hold_results = 1'b0;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 0;
        key_pool[3] = -1;
        for (int i = 4; i < 8; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(REQ_LIST, 0, 0, '0);
        send_request(REQ_LOOKUP, 5, 0, '0);
        send_request(REQ_UPDATE, 5, 32'h1234_5678, 31'd77);
        send_request(REQ_DELETE, 5, 0, '0);
        send_request(REQ_INSERT, 32'sh8000_0000, '0, '0);
        send_request(REQ_INSERT, 32'sh7fff_ffff, '1, '1);
        send_request(REQ_INSERT, 0, 32'h1111_1111, 31'd100);
        send_request(REQ_INSERT, 0, 32'h2222_2222, 31'd200);
        send_request(REQ_LOOKUP, 0, 0, '0);
        send_request(REQ_UPDATE, 0, 32'h3333_3333, 31'd300);
        send_request(REQ_DELETE, 0, 0, '0);
        send_request(REQ_LOOKUP, 0, 0, '0);
        send_request(REQ_DELETE, 32'sh8000_0000, 0, '0);
        for (int c = REQ_LIST + 1; c < 8; c++) begin
            send_request(t_req'(c), $urandom, $urandom, POP_W'($urandom));
        end
        send_request(REQ_LIST, 0, 0, '0);
        for (int i = 2; i < CAPACITY; i++) begin
            send_request(REQ_INSERT, i * 1000 - 7000, $urandom, POP_W'($urandom));
        end
        send_request(REQ_INSERT, 42, $urandom, POP_W'($urandom));
        send_request(REQ_LIST, 0, 0, '0);
        send_request(REQ_DELETE, (CAPACITY - 1) * 1000 - 7000, 0, '0);
        wait_drained();

        run_phase(12, 12, 40, 15, 1'b1);
        run_phase(0, 0, 30, 25, 1'b0);
        run_phase(12, 12, 5, 60, 1'b0);
        run_phase(4, 12, 30, 25, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("%0d requests accepted, %0d result beats checked", requests_sent,
                 beats_checked);
        $display("covered empty and full table, duplicate keys, misses, long result stall");
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> keyed_record_table.f
hdl/kbt_pkg.sv
hdl/kbt_req_if.sv
hdl/kbt_rsp_if.sv
hdl/kbt_cell.sv
hdl/kbt_ctrl.sv
hdl/keyed_record_table.sv
tb/sv/record_table_checker.sv
tb/sv/tb_top.sv
